FILE: hdl/assert_macros.svh
// Assertion helpers used by biou_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked during reset too.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset behavior");

`endif

FILE: hdl/biou_pkg.sv
package biou_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int AREA_W  = 2 * COORD_BITS;
  localparam int UNI_W   = AREA_W + 1;
  localparam int RATIO_W = FRAC_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_W-1:0]     area_t;
  typedef logic [UNI_W-1:0]      uni_t;
  typedef logic [RATIO_W-1:0]    ratio_t;

  // Word carried down the divider chain.
  typedef struct packed {
    uni_t   rem;    // partial remainder, below div unless the union is empty
    logic   lsb;    // next dividend bit to shift in (zero after first cell)
    uni_t   div;    // union area
    ratio_t quo;    // quotient bits so far
    logic   empty;  // union area is zero
  } div_word_t;

endpackage

FILE: hdl/biou_ifs.sv
interface biou_in_if;
  import biou_pkg::*;
  logic   valid;
  logic   ready;
  coord_t a_left;
  coord_t a_top;
  coord_t a_width;
  coord_t a_height;
  coord_t b_left;
  coord_t b_top;
  coord_t b_width;
  coord_t b_height;

  modport source (output valid, a_left, a_top, a_width, a_height,
                  b_left, b_top, b_width, b_height, input ready);
  modport sink   (input valid, a_left, a_top, a_width, a_height,
                  b_left, b_top, b_width, b_height, output ready);
endinterface

interface biou_out_if;
  import biou_pkg::*;
  logic   valid;
  logic   ready;
  ratio_t ratio;
  logic   union_empty;

  modport source (output valid, ratio, union_empty, input ready);
  modport sink   (input valid, ratio, union_empty, output ready);
endinterface

FILE: hdl/biou_front.sv
module biou_front (
  input  logic                clk,
  input  logic                rst_n,
  biou_in_if.sink             in_ch,
  output logic                dn_valid,
  input  logic                dn_ready,
  output biou_pkg::div_word_t dn_word
);
  import biou_pkg::*;

  // Clipped overlap of [lo1, lo1+len1) and [lo2, lo2+len2).
  function automatic coord_t span_overlap(coord_t lo1, coord_t len1,
                                          coord_t lo2, coord_t len2);
    logic [COORD_BITS:0] hi1;
    logic [COORD_BITS:0] hi2;
    logic [COORD_BITS:0] lo;
    logic [COORD_BITS:0] hi;
    logic [COORD_BITS:0] d;
    hi1 = {1'b0, lo1} + {1'b0, len1};
    hi2 = {1'b0, lo2} + {1'b0, len2};
    lo  = (lo1 > lo2) ? {1'b0, lo1} : {1'b0, lo2};
    hi  = (hi1 < hi2) ? hi1 : hi2;
    d   = hi - lo;
    return (hi > lo) ? d[COORD_BITS-1:0] : '0;
  endfunction

  // stage A: overlaps
  logic   va_r;
  coord_t ox_r, oy_r, aw_r, ah_r, bw_r, bh_r;
  // stage B: areas
  logic   vb_r;
  area_t  inter_r, area_a_r, area_b_r;
  // stage C: union and divider seed
  logic      vc_r;
  div_word_t word_r;

  logic en_a, en_b, en_c;
  uni_t uni_nxt;

  assign en_c = !vc_r || dn_ready;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_ch.ready = en_a;

  assign uni_nxt = {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_ch.valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ox_r <= span_overlap(in_ch.a_left, in_ch.a_width, in_ch.b_left, in_ch.b_width);
      oy_r <= span_overlap(in_ch.a_top, in_ch.a_height, in_ch.b_top, in_ch.b_height);
      aw_r <= in_ch.a_width;
      ah_r <= in_ch.a_height;
      bw_r <= in_ch.b_width;
      bh_r <= in_ch.b_height;
    end
    if (en_b) begin
      inter_r  <= ox_r * oy_r;
      area_a_r <= aw_r * ah_r;
      area_b_r <= bw_r * bh_r;
    end
    if (en_c) begin
      // high dividend bits give remainder inter/2; inter[0] is the next bit
      word_r.rem   <= UNI_W'(inter_r[AREA_W-1:1]);
      word_r.lsb   <= inter_r[0];
      word_r.div   <= uni_nxt;
      word_r.quo   <= '0;
      word_r.empty <= (uni_nxt == '0);
    end
  end

  assign dn_valid = vc_r;
  assign dn_word  = word_r;

endmodule

FILE: hdl/biou_div_cell.sv
module biou_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  biou_pkg::div_word_t up_word,
  output logic                dn_valid,
  input  logic                dn_ready,
  output biou_pkg::div_word_t dn_word
);
  import biou_pkg::*;

  logic            v_r;
  div_word_t       word_r;
  logic            en;
  logic [UNI_W:0]  trial;
  logic [UNI_W:0]  diff;
  logic            fits;
  div_word_t       word_nxt;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;

  // one restoring-division step
  always_comb begin
    trial = {up_word.rem, up_word.lsb};
    diff  = trial - {1'b0, up_word.div};
    fits  = (trial >= {1'b0, up_word.div});
    word_nxt       = up_word;
    word_nxt.rem   = fits ? diff[UNI_W-1:0] : trial[UNI_W-1:0];
    word_nxt.lsb   = 1'b0;
    word_nxt.quo   = {up_word.quo[RATIO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = word_r;

endmodule

FILE: hdl/box_iou_unit.sv
// Pipeline: 3 + RATIO_W register stages (20 at 16 fraction bits) for
//   overlap, areas, union, then one cell of the divider chain per
//   quotient bit.
// Throughput: one word per cycle; each stage holds its word while stalled.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
module box_iou_unit (
  input  logic       clk,
  input  logic       rst_n,
  biou_in_if.sink    in_ch,
  biou_out_if.source out_ch
);
  import biou_pkg::*;

  // Chain links: index 0 is the front end output, index RATIO_W the last cell.
  logic      link_valid [RATIO_W+1];
  logic      link_ready [RATIO_W+1];
  div_word_t link_word  [RATIO_W+1];

  // Overlap, area products and union, three register stages.
  biou_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_word  (link_word[0])
  );

  // Divider: one cell per quotient bit, MSB first. Each cell shifts the
  // partial remainder left, subtracts the union when it fits and shifts
  // the resulting bit into the quotient.
  for (genvar i = 0; i < RATIO_W; i++) begin : g_cell
    biou_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_ready (link_ready[i]),
      .up_word  (link_word[i]),
      .dn_valid (link_valid[i+1]),
      .dn_ready (link_ready[i+1]),
      .dn_word  (link_word[i+1])
    );
  end

  // The last cell is the output register. With a zero union every trial
  // subtract "fits", so the quotient is masked to zero there.
  assign link_ready[RATIO_W] = out_ch.ready;
  assign out_ch.valid        = link_valid[RATIO_W];
  assign out_ch.union_empty  = link_word[RATIO_W].empty;
  assign out_ch.ratio        = link_word[RATIO_W].empty ? '0 : link_word[RATIO_W].quo;

endmodule

FILE: hdl/biou_checker.sv
`include "assert_macros.svh"

module biou_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input biou_pkg::ratio_t     ratio,
  input logic                 union_empty
);
  import biou_pkg::*;

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(ratio) && $stable(union_empty))

  // empty union always reports a zero ratio
  `ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && union_empty, ratio == '0)

  // ratio never exceeds 1.0
  `ASSERT_IMPLY(a_ratio_max, clk, rst_n, out_valid && ratio[FRAC_BITS], ratio[FRAC_BITS-1:0] == '0)

  // reset empties the pipeline
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind box_iou_unit biou_checker u_biou_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .ratio       (out_ch.ratio),
  .union_empty (out_ch.union_empty)
);

FILE: dv/iou_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each result from the accepted word and
// compares in order.
module iou_checker
  import biou_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  biou_in_if   in_ch,
  biou_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked_count,
  output int   empty_count,
  output int   full_count
);

  localparam int MAX_PRINTS = 20;

  typedef struct packed {
    ratio_t ratio;
    logic   union_empty;
  } iou_result_t;

  iou_result_t iou_expected_q[$];

  function automatic logic [COORD_BITS:0] axis_overlap(coord_t lo_a, coord_t len_a,
                                                       coord_t lo_b, coord_t len_b);
    logic [COORD_BITS:0] hi_a, hi_b, lo, hi;
    hi_a = {1'b0, lo_a} + {1'b0, len_a};
    hi_b = {1'b0, lo_b} + {1'b0, len_b};
    lo   = (lo_a > lo_b) ? {1'b0, lo_a} : {1'b0, lo_b};
    hi   = (hi_a < hi_b) ? hi_a : hi_b;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic iou_result_t iou_of_boxes(coord_t al, coord_t at, coord_t aw, coord_t ah,
                                               coord_t bl, coord_t bt, coord_t bw, coord_t bh);
    iou_result_t                     r;
    logic [COORD_BITS:0]             ox, oy;
    area_t                           inter, area_a, area_b;
    uni_t                            uni;
    logic [AREA_W+FRAC_BITS-1:0]     num, quo;
    ox     = axis_overlap(al, aw, bl, bw);
    oy     = axis_overlap(at, ah, bt, bh);
    inter  = area_t'(ox) * area_t'(oy);
    area_a = area_t'(aw) * area_t'(ah);
    area_b = area_t'(bw) * area_t'(bh);
    uni    = uni_t'(area_a) + uni_t'(area_b) - uni_t'(inter);
    r      = '0;
    if (uni == '0) begin
      r.union_empty = 1'b1;
    end else begin
      num     = {inter, {FRAC_BITS{1'b0}}};
      quo     = num / uni;
      r.ratio = quo[RATIO_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("%0t ERROR result %0d: %s got %0d, expected %0d",
               $time, checked_count, what, got, want);
  endtask

  always @(posedge clk) begin
    iou_result_t want;
    if (!rst_n) begin
      iou_expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (iou_expected_q.size() == 0) begin
          report_mismatch("word with nothing expected, ratio", longint'(out_ch.ratio), -1);
        end else begin
          want = iou_expected_q.pop_front();
          if (out_ch.ratio !== want.ratio)
            report_mismatch("ratio", longint'(out_ch.ratio), longint'(want.ratio));
          if (out_ch.union_empty !== want.union_empty)
            report_mismatch("union_empty", longint'(out_ch.union_empty),
                            longint'(want.union_empty));
          if (want.union_empty) empty_count++;
          if (want.ratio == ratio_t'(1) << FRAC_BITS) full_count++;
        end
        checked_count++;
      end
      if (in_ch.valid && in_ch.ready)
        iou_expected_q.insert(iou_expected_q.size(),
                              iou_of_boxes(in_ch.a_left, in_ch.a_top, in_ch.a_width,
                                           in_ch.a_height, in_ch.b_left, in_ch.b_top,
                                           in_ch.b_width, in_ch.b_height));
    end
    pending = iou_expected_q.size();
  end

endmodule

FILE: dv/tb_box_iou_unit.sv
`timescale 1ns / 100ps

// Box IoU unit testbench.
// Stimulus only lives here; iou_checker does prediction and compare.
module tb_box_iou_unit;
  import biou_pkg::*;

  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int RANDOM_WORDS = 1030;
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off, fills the pipe
  localparam int HOLD_AFTER   = 300;   // words sent before the hold-off starts
  localparam int DRAIN_CYCLES = 40;    // pipe is 20 deep

  typedef struct {
    coord_t a_left, a_top, a_width, a_height;
    coord_t b_left, b_top, b_width, b_height;
  } box_pair_t;

  logic clk;
  logic rst_n;

  biou_in_if  in_ch ();
  biou_out_if out_ch ();

  box_iou_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int fail_count, pending, checked_count, empty_count, full_count;

  iou_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .empty_count   (empty_count),
    .full_count    (full_count)
  );

  // hold_rx: receiver forced low, set by the squeeze process
  bit hold_rx;
  int words_sent;
  int directed_words;
  int in_stall_cycles;
  // sender calm stretch: no gaps while it lasts
  bit tx_calm;
  int tx_calm_left;

  box_pair_t directed_q[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles where the block pushed back on a waiting word.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cycles++;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic box_pair_t mk_pair(int al, int at, int aw, int ah,
                                        int bl, int bt, int bw, int bh);
    box_pair_t p;
    p.a_left = coord_t'(al); p.a_top = coord_t'(at);
    p.a_width = coord_t'(aw); p.a_height = coord_t'(ah);
    p.b_left = coord_t'(bl); p.b_top = coord_t'(bt);
    p.b_width = coord_t'(bw); p.b_height = coord_t'(bh);
    return p;
  endfunction

  // Append a pair to the directed list.
  function automatic void add_directed(box_pair_t p);
    directed_q.insert(directed_q.size(), p);
  endfunction

  // Field value biased to the corners of its range.
  function automatic coord_t corner_coord();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return coord_t'(1);
      2: return coord_t'(COORD_MAX - 1);
      3: return coord_t'(COORD_MAX);
      default: return coord_t'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  // Random pair: mostly overlapping boxes so the divider sees real
  // fractions, plus fully random, identical, zero-area and corner pairs.
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int        kind, span, dx, dy, dw, dh;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       span = 15;
      1:       span = COORD_MAX;
      default: span = 255;
    endcase
    p.a_left   = coord_t'($urandom_range(0, COORD_MAX));
    p.a_top    = coord_t'($urandom_range(0, COORD_MAX));
    p.a_width  = coord_t'($urandom_range(0, span));
    p.a_height = coord_t'($urandom_range(0, span));
    p.b_left   = coord_t'($urandom_range(0, COORD_MAX));
    p.b_top    = coord_t'($urandom_range(0, COORD_MAX));
    p.b_width  = coord_t'($urandom_range(0, span));
    p.b_height = coord_t'($urandom_range(0, span));
    if (kind < 15) begin
      p.a_width  = coord_t'($urandom_range(0, COORD_MAX));
      p.a_height = coord_t'($urandom_range(0, COORD_MAX));
      p.b_width  = coord_t'($urandom_range(0, COORD_MAX));
      p.b_height = coord_t'($urandom_range(0, COORD_MAX));
    end else if (kind < 70) begin
      // b is a jittered copy of a
      dx = int'($urandom_range(0, 2 * p.a_width + 2)) - int'(p.a_width) - 1;
      dy = int'($urandom_range(0, 2 * p.a_height + 2)) - int'(p.a_height) - 1;
      dw = int'($urandom_range(0, p.a_width + 2)) - int'(p.a_width / 2) - 1;
      dh = int'($urandom_range(0, p.a_height + 2)) - int'(p.a_height / 2) - 1;
      p.b_left   = clamp_coord(int'(p.a_left) + dx);
      p.b_top    = clamp_coord(int'(p.a_top) + dy);
      p.b_width  = clamp_coord(int'(p.a_width) + dw);
      p.b_height = clamp_coord(int'(p.a_height) + dh);
    end else if (kind < 80) begin
      p.b_left   = p.a_left;
      p.b_top    = p.a_top;
      p.b_width  = p.a_width;
      p.b_height = p.a_height;
    end else if (kind < 88) begin
      // one or both boxes flattened
      if ($urandom_range(0, 1)) p.a_width = '0; else p.a_height = '0;
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 1)) p.b_width = '0; else p.b_height = '0;
      end
    end else begin
      p.a_left   = corner_coord();
      p.a_top    = corner_coord();
      p.a_width  = corner_coord();
      p.a_height = corner_coord();
      p.b_left   = corner_coord();
      p.b_top    = corner_coord();
      p.b_width  = corner_coord();
      p.b_height = corner_coord();
    end
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(input box_pair_t p);
    int gap;
    if (tx_calm_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_calm_left = $urandom_range(20, 120);
    end else begin
      tx_calm_left--;
    end
    gap = (hold_rx || tx_calm) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.a_left   <= p.a_left;
    in_ch.a_top    <= p.a_top;
    in_ch.a_width  <= p.a_width;
    in_ch.a_height <= p.a_height;
    in_ch.b_left   <= p.b_left;
    in_ch.b_top    <= p.b_top;
    in_ch.b_width  <= p.b_width;
    in_ch.b_height <= p.b_height;
    in_ch.valid    <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Result side: random ready with calm stretches; forced low on hold_rx.
  initial begin : result_drain
    int idle_left;
    int calm_left;
    bit calm;
    idle_left    = 0;
    calm_left    = 0;
    calm         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm) idle_left = pick_gap();
      end
    end
  end

  // One long hold-off on the result side while the sender keeps pushing.
  initial begin : squeeze
    hold_rx = 1'b0;
    wait (words_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("box_iou_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid    = 1'b0;
    in_ch.a_left   = '0;
    in_ch.a_top    = '0;
    in_ch.a_width  = '0;
    in_ch.a_height = '0;
    in_ch.b_left   = '0;
    in_ch.b_top    = '0;
    in_ch.b_width  = '0;
    in_ch.b_height = '0;
    words_sent      = 0;
    in_stall_cycles = 0;
    tx_calm         = 1'b0;
    tx_calm_left    = 0;
    rst_n           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identical boxes, small and full size -> ratio of exactly one
    add_directed(mk_pair(10, 20, 30, 40, 10, 20, 30, 40));
    add_directed(mk_pair(0, 0, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX));
    // right/bottom edges past the coordinate range, must not wrap
    add_directed(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    add_directed(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                         0, 0, COORD_MAX, COORD_MAX));
    // empty union: all zero, and two flat boxes of different kinds
    add_directed(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    add_directed(mk_pair(100, 100, 0, 50, 100, 100, 50, 0));
    add_directed(mk_pair(COORD_MAX, 0, 0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0));
    // flat box against a real one
    add_directed(mk_pair(5, 5, 0, 10, 0, 0, 20, 20));
    add_directed(mk_pair(0, 0, 20, 20, 5, 5, 10, 0));
    // touching edges in x, then in y, then fully apart
    add_directed(mk_pair(0, 0, 10, 10, 10, 0, 10, 10));
    add_directed(mk_pair(0, 0, 10, 10, 0, 10, 10, 10));
    add_directed(mk_pair(0, 0, 10, 10, 500, 600, 10, 10));
    // containment and partial overlap
    add_directed(mk_pair(0, 0, 100, 100, 25, 25, 50, 50));
    add_directed(mk_pair(0, 0, 100, 100, 50, 50, 100, 100));
    add_directed(mk_pair(0, 0, 3, 1, 1, 0, 3, 1));
    // tiny box in a huge one: ratio rounds to zero or near it
    add_directed(mk_pair(0, 0, COORD_MAX, COORD_MAX, 0, 0, 1, 1));
    add_directed(mk_pair(0, 0, COORD_MAX, COORD_MAX, 7, 9, 64, 64));
    // just short of one
    add_directed(mk_pair(0, 0, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX - 1));
    // alternating bit patterns
    add_directed(mk_pair('hAAA, 'h555, 'hAAA, 'h555, 'h555, 'hAAA, 'h555, 'hAAA));
    add_directed(mk_pair('h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA));
    directed_words = directed_q.size();
    foreach (directed_q[i]) send_pair(directed_q[i]);

    repeat (RANDOM_WORDS) send_pair(random_pair());
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d box pairs (%0d directed), %0d results checked",
             words_sent, directed_words, checked_count);
    $display("empty unions %0d, full overlaps %0d, input stall cycles %0d",
             empty_count, full_count, in_stall_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("box_iou_unit verification clean");
    end else begin
      $display("box_iou_unit verification failed");
    end
    $finish;
  end

endmodule
